// ===== rtl/pulse_threshold_crossing_timer_assert.svh =====
// Assertion macros for the pulse threshold crossing timer RTL.
`ifndef PULSE_THRESHOLD_CROSSING_TIMER_ASSERT_SVH
`define PULSE_THRESHOLD_CROSSING_TIMER_ASSERT_SVH

// Same-cycle implication, clocked on clk, disabled while rst_n is low.
`define PTCT_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, disabled while rst_n is low.
`define PTCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ptct_pkg.sv =====
// Shared types, widths and codes of the pulse threshold crossing timer.
package ptct_pkg;

    // Window and field widths
    localparam int MAX_WINDOW = 1024;
    localparam int SAMPLE_W   = 14;
    localparam int BASE_W     = 18;
    localparam int THR_W      = 19;
    localparam int PEAK_W     = 19;
    localparam int TIME_W     = 18;
    localparam int STATUS_W   = 2;
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int RUN_W      = 4;
    localparam int OFFSET_W   = 14;
    localparam int FRAC_W     = 8;

    // Interpolation divider: numerator up to 20 bits, scaled by 16
    localparam int NUM_W      = 21;
    localparam int DEN_W      = SAMPLE_W + 1;
    localparam int DIV_N_W    = 24;
    localparam int DIV_CNT_W  = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd24;

    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_WINDOW - 1);
    localparam logic [RUN_W-1:0] RUN_MAX = 4'd15;

    // APB port
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_THR_OFFSET = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_RUN    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_START  = 2'd2;

    localparam logic [OFFSET_W-1:0] THR_OFFSET_RST = 14'd5;
    localparam logic [RUN_W-1:0]    MIN_RUN_RST    = 4'd3;
    localparam logic [SAMPLE_W-1:0] MIN_START_RST  = 14'd1000;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_CROSS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ORDER    = 2'd2;

    typedef struct packed {
        logic [OFFSET_W-1:0] threshold_offset;
        logic [RUN_W-1:0]    min_run;
        logic [SAMPLE_W-1:0] min_start;
    } cfg_t;

    typedef struct packed {
        logic sample_en;
        logic div_start;
        logic div_sel;
        logic frac_load;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
    } dp_status_t;

    typedef struct packed {
        logic signed [PEAK_W-1:0] peak_amplitude;
        logic [TIME_W-1:0]        start_time;
        logic [TIME_W-1:0]        end_time;
        logic [TIME_W-1:0]        pulse_width;
        logic [STATUS_W-1:0]      status;
    } result_t;

endpackage

// ===== rtl/ptct_ifs.sv =====
// Sample input and result output stream interfaces.
interface ptct_in_if import ptct_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic [BASE_W-1:0]   baseline;
    logic                last;

    modport source (output valid, sample, baseline, last, input ready);
    modport sink (input valid, sample, baseline, last, output ready);
endinterface

interface ptct_out_if import ptct_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [PEAK_W-1:0] peak_amplitude;
    logic [TIME_W-1:0]        start_time;
    logic [TIME_W-1:0]        end_time;
    logic [TIME_W-1:0]        pulse_width;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, peak_amplitude, start_time, end_time, pulse_width, status,
                    input ready);
    modport sink (input valid, peak_amplitude, start_time, end_time, pulse_width, status,
                  output ready);
endinterface

// ===== rtl/ptct_regs.sv =====
// APB configuration registers: threshold offset, minimum run, minimum start.
module ptct_regs import ptct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [OFFSET_W-1:0]  thr_offset_reg;
    logic [RUN_W-1:0]     min_run_reg;
    logic [SAMPLE_W-1:0]  min_start_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_offset_reg <= THR_OFFSET_RST;
            min_run_reg    <= MIN_RUN_RST;
            min_start_reg  <= MIN_START_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_THR_OFFSET: thr_offset_reg <= pwdata[OFFSET_W-1:0];
                REG_MIN_RUN:    min_run_reg    <= pwdata[RUN_W-1:0];
                REG_MIN_START:  min_start_reg  <= pwdata[SAMPLE_W-1:0];
                default:        ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            REG_THR_OFFSET: prdata = PDATA_W'(thr_offset_reg);
            REG_MIN_RUN:    prdata = PDATA_W'(min_run_reg);
            REG_MIN_START:  prdata = PDATA_W'(min_start_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.threshold_offset = thr_offset_reg;
    assign cfg.min_run          = min_run_reg;
    assign cfg.min_start        = min_start_reg;

endmodule

// ===== rtl/ptct_div.sv =====
// Restoring divider, one quotient bit per cycle; keeps the low quotient byte.
module ptct_div import ptct_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DIV_N_W-1:0]  dividend,
    input  logic [SAMPLE_W-1:0] divisor,
    output logic                busy,
    output logic [FRAC_W-1:0]   quot
);

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_N_W-1:0]   n_reg;
    logic [SAMPLE_W-1:0]  d_reg;
    logic [SAMPLE_W-1:0]  rem_reg;
    logic [FRAC_W-1:0]    q_reg;
    logic [SAMPLE_W:0]    rem_sh;
    logic [SAMPLE_W:0]    rem_diff;
    logic                 fits;

    assign busy = (cnt_reg != '0);
    assign quot = q_reg;

    // one trial subtract per step
    assign rem_sh   = {rem_reg, n_reg[DIV_N_W-1]};
    assign fits     = (rem_sh >= {1'b0, d_reg});
    assign rem_diff = rem_sh - {1'b0, d_reg};

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= DIV_STEPS;
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // shift and subtract
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= dividend;
            d_reg   <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy)
        begin
            n_reg   <= {n_reg[DIV_N_W-2:0], 1'b0};
            rem_reg <= fits ? rem_diff[SAMPLE_W-1:0] : rem_sh[SAMPLE_W-1:0];
            q_reg   <= {q_reg[FRAC_W-2:0], fits};
        end
    end

endmodule

// ===== rtl/ptct_datapath.sv =====
// Per-sample tracking of minimum and crossing runs, interpolation and result register.
module ptct_datapath import ptct_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  dp_cmd_t             cmd,
    output dp_status_t          stat,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [BASE_W-1:0]   baseline,
    input  logic                last,
    output result_t             res
);

    // control-like state, cleared by reset
    logic [IDX_W-1:0]    idx_reg;
    logic [RUN_W-1:0]    run_reg;
    logic                ff_reg;
    logic                ep_reg;

    // payload state
    logic [IDX_W-1:0]        k_reg;
    logic [BASE_W-1:0]       base_reg;
    logic signed [THR_W-1:0] thr_reg;
    logic [SAMPLE_W-1:0]     min_reg;
    logic [SAMPLE_W-1:0]     prev_reg;
    logic [IDX_W-1:0]        first_idx_reg;
    logic [SAMPLE_W-1:0]     fy0_reg;
    logic [SAMPLE_W-1:0]     fy1_reg;
    logic [IDX_W-1:0]        end_idx_reg;
    logic [SAMPLE_W-1:0]     ey0_reg;
    logic [SAMPLE_W-1:0]     ey1_reg;
    logic                    fok1_reg;
    logic                    fok2_reg;
    logic [FRAC_W-1:0]       frac1_reg;
    logic [FRAC_W-1:0]       frac2_reg;
    result_t                 res_reg;

    logic                    k0;
    logic signed [THR_W-1:0] thr_first;
    logic signed [THR_W-1:0] thr_cur;
    logic [SAMPLE_W-1:0]     min_cur;
    logic [RUN_W-1:0]        run_cur;
    logic                    ff_cur;
    logic                    ep_cur;
    logic [RUN_W-1:0]        mr;
    logic [RUN_W-1:0]        run_inc;
    logic                    below;
    logic                    run_start;
    logic                    run_closes;

    logic signed [NUM_W-1:0] num1;
    logic signed [NUM_W-1:0] num2;
    logic signed [NUM_W-1:0] num_sel;
    logic signed [DEN_W-1:0] den1;
    logic signed [DEN_W-1:0] den2;
    logic signed [DEN_W-1:0] den_sel;
    logic                    frac_ok;
    logic                    div_busy;
    logic [FRAC_W-1:0]       div_q;

    logic signed [PEAK_W-1:0] peak;
    logic [TIME_W-1:0]        t1;
    logic [TIME_W-1:0]        t2;
    result_t                  res_next;

    // sample classification, with the window start taking fresh values
    assign k0        = (idx_reg == '0);
    assign thr_first = $signed({1'b0, baseline}) - $signed({1'b0, cfg.threshold_offset, 4'b0});
    assign thr_cur   = k0 ? thr_first : thr_reg;
    assign min_cur   = k0 ? cfg.min_start : min_reg;
    assign run_cur   = k0 ? '0 : run_reg;
    assign ff_cur    = k0 ? 1'b0 : ff_reg;
    assign ep_cur    = k0 ? 1'b0 : ep_reg;
    assign mr        = (cfg.min_run == '0) ? RUN_W'(1) : cfg.min_run;
    assign run_inc   = (run_cur == RUN_MAX) ? run_cur : run_cur + 1'b1;
    assign below     = $signed({2'b00, sample, 4'b0}) < $signed({thr_cur[THR_W-1], thr_cur});
    assign run_start = below && (run_cur == '0) && !ff_cur;
    assign run_closes = !below && (run_cur >= mr);

    // run tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            run_reg <= '0;
            ff_reg  <= 1'b0;
            ep_reg  <= 1'b0;
        end
        else if (cmd.sample_en)
        begin
            if (last)
            begin
                idx_reg <= '0;
            end
            else if (idx_reg != IDX_MAX)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            run_reg <= below ? run_inc : '0;
            ff_reg  <= ff_cur || (below && (run_inc >= mr));
            ep_reg  <= ep_cur || run_closes;
        end
    end

    // per-sample payload: baseline, threshold, minimum and crossing pairs
    always_ff @(posedge clk)
    begin
        if (cmd.sample_en)
        begin
            k_reg    <= idx_reg;
            base_reg <= k0 ? baseline : base_reg;
            thr_reg  <= thr_cur;
            min_reg  <= (sample < min_cur) ? sample : min_cur;
            prev_reg <= sample;
            if (run_start)
            begin
                first_idx_reg <= idx_reg;
                fy0_reg       <= prev_reg;
                fy1_reg       <= sample;
            end
            if (run_closes)
            begin
                end_idx_reg <= idx_reg - 1'b1;
                ey0_reg     <= prev_reg;
                ey1_reg     <= sample;
            end
        end
    end

    // interpolation operands: start and end each use the pair across the crossing
    assign num1 = $signed({3'b000, fy0_reg, 4'b0}) - $signed({{2{thr_reg[THR_W-1]}}, thr_reg});
    assign den1 = $signed({1'b0, fy0_reg}) - $signed({1'b0, fy1_reg});
    assign num2 = $signed({{2{thr_reg[THR_W-1]}}, thr_reg}) - $signed({3'b000, ey0_reg, 4'b0});
    assign den2 = $signed({1'b0, ey1_reg}) - $signed({1'b0, ey0_reg});

    assign num_sel = cmd.div_sel ? num2 : num1;
    assign den_sel = cmd.div_sel ? den2 : den1;
    assign frac_ok = !num_sel[NUM_W-1] && (num_sel != '0) &&
                     !den_sel[DEN_W-1] && (den_sel != '0);

    ptct_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({num_sel[NUM_W-2:0], 4'b0}),
        .divisor  (den_sel[SAMPLE_W-1:0]),
        .busy     (div_busy),
        .quot     (div_q)
    );

    assign stat.div_busy = div_busy;

    // fraction capture; a non-positive step gives a zero fraction
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            if (cmd.div_sel)
            begin
                fok2_reg <= frac_ok;
            end
            else
            begin
                fok1_reg <= frac_ok;
            end
        end
        if (cmd.frac_load)
        begin
            if (cmd.div_sel)
            begin
                frac2_reg <= fok2_reg ? div_q : '0;
            end
            else
            begin
                frac1_reg <= fok1_reg ? div_q : '0;
            end
        end
    end

    // result assembly
    assign peak = $signed({1'b0, base_reg}) - $signed({1'b0, min_reg, 4'b0});

    always_comb
    begin
        if ((first_idx_reg == '0) || (first_idx_reg >= k_reg))
        begin
            t1 = TIME_W'({first_idx_reg, 8'b0});
        end
        else
        begin
            t1 = TIME_W'({first_idx_reg - 1'b1, frac1_reg});
        end

        if (run_reg >= mr)
        begin
            t2 = TIME_W'({k_reg, 8'b0});
        end
        else if (ep_reg && (end_idx_reg != '0))
        begin
            t2 = TIME_W'({end_idx_reg, frac2_reg});
        end
        else
        begin
            t2 = '0;
        end

        res_next.peak_amplitude = peak;
        if (!ff_reg)
        begin
            res_next.start_time  = '0;
            res_next.end_time    = '0;
            res_next.pulse_width = '0;
            res_next.status      = STATUS_NO_CROSS;
        end
        else if (t1 < t2)
        begin
            res_next.start_time  = t1;
            res_next.end_time    = t2;
            res_next.pulse_width = t2 - t1;
            res_next.status      = STATUS_OK;
        end
        else
        begin
            res_next.start_time  = t1;
            res_next.end_time    = t2;
            res_next.pulse_width = '0;
            res_next.status      = STATUS_ORDER;
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== rtl/ptct_ctrl.sv =====
// Controller: sample acceptance, two interpolation divisions, result handoff.
`include "pulse_threshold_crossing_timer_assert.svh"

module ptct_ctrl import ptct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_last,
    output logic       in_ready,
    input  logic       out_ready,
    output logic       out_valid,
    input  dp_status_t stat,
    output dp_cmd_t    cmd
);

    localparam logic [2:0] ST_RUN     = 3'd0;
    localparam logic [2:0] ST_D1_GO   = 3'd1;
    localparam logic [2:0] ST_D1_WAIT = 3'd2;
    localparam logic [2:0] ST_D2_GO   = 3'd3;
    localparam logic [2:0] ST_D2_WAIT = 3'd4;
    localparam logic [2:0] ST_RESULT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.sample_en = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_sel   = 1'b0;
        cmd.frac_load = 1'b0;
        cmd.out_load  = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                in_ready      = 1'b1;
                cmd.sample_en = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = ST_D1_GO;
                end
            end
            ST_D1_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_D1_WAIT;
            end
            ST_D1_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.frac_load = 1'b1;
                    state_next    = ST_D2_GO;
                end
            end
            ST_D2_GO:
            begin
                cmd.div_sel   = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = ST_D2_WAIT;
            end
            ST_D2_WAIT:
            begin
                cmd.div_sel = 1'b1;
                if (!stat.div_busy)
                begin
                    cmd.frac_load = 1'b1;
                    state_next    = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // output word valid
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // checks
    `PTCT_ASSERT_NEXT(a_last_stalls_input, in_valid && in_ready && in_last, !in_ready, "input not stalled after last word")
    `PTCT_ASSERT_IMPLY(a_div_busy_in_wait, stat.div_busy, (state_reg == ST_D1_WAIT) || (state_reg == ST_D2_WAIT), "divider busy outside a wait state")
    `PTCT_ASSERT_NEXT(a_load_shows_word, cmd.out_load, out_valid && (state_reg == ST_RUN), "loaded result word not presented")

endmodule

// ===== rtl/pulse_threshold_crossing_timer.sv =====
// Throughput: one sample per cycle while the input is open; after the last sample
// the input is held off until the result word is loaded, which waits on the shared
// bit-serial divider running the start and end interpolations (24 steps each) one
// after the other, and on the previous result word being taken.
// Reset: rst_n clears registers to defaults, the sample index and run state; no
// result is pending after reset.
module pulse_threshold_crossing_timer import ptct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    ptct_in_if.sink            din,
    ptct_out_if.source         dout
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t stat;
    result_t    res;

    ptct_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ptct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (din.valid),
        .in_last   (din.last),
        .in_ready  (din.ready),
        .out_ready (dout.ready),
        .out_valid (dout.valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    ptct_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .stat     (stat),
        .sample   (din.sample),
        .baseline (din.baseline),
        .last     (din.last),
        .res      (res)
    );

    assign dout.peak_amplitude = res.peak_amplitude;
    assign dout.start_time     = res.start_time;
    assign dout.end_time       = res.end_time;
    assign dout.pulse_width    = res.pulse_width;
    assign dout.status         = res.status;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the pulse threshold crossing timer.
module tb_top;
    import ptct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 500000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    ptct_in_if  din_if();
    ptct_out_if dout_if();

    pulse_threshold_crossing_timer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .din     (din_if),
        .dout    (dout_if)
    );

    always #1 clk = ~clk;

    // Shared bookkeeping
    result_t     expected_pulses[$];
    result_t     want;
    int          mismatch_count = 0;
    int          samples_sent   = 0;
    int          cycle_count    = 0;
    int          gap_max        = 4;
    int          stall_max      = 4;

    // Register copies
    logic [OFFSET_W-1:0] cfg_offset    = THR_OFFSET_RST;
    logic [RUN_W-1:0]    cfg_min_run   = MIN_RUN_RST;
    logic [SAMPLE_W-1:0] cfg_min_start = MIN_START_RST;

    // Discriminator state
    logic [IDX_W-1:0]    wf_idx     = '0;
    int                  thr_level  = 0;
    logic [BASE_W-1:0]   base_lat   = '0;
    logic [SAMPLE_W-1:0] min_val    = MIN_START_RST;
    logic [RUN_W-1:0]    run_len    = '0;
    logic [SAMPLE_W-1:0] prev_s     = '0;
    bit                  start_seen = 1'b0;
    logic [IDX_W-1:0]    start_idx  = '0;
    logic [SAMPLE_W-1:0] start_y0   = '0;
    logic [SAMPLE_W-1:0] start_y1   = '0;
    logic [IDX_W-1:0]    end_idx    = '0;
    logic [SAMPLE_W-1:0] end_y0     = '0;
    logic [SAMPLE_W-1:0] end_y1     = '0;
    bit                  end_seen   = 1'b0;

    // Truncated 8-bit interpolation fraction; zero for a non-positive step
    function automatic int interp_fraction(input int num, input int den);
        if (num <= 0 || den <= 0)
            return 0;
        return ((num * 16) / den) & 8'hFF;
    endfunction

    // Advance the discriminator by one accepted sample; queue a pulse word on last
    function automatic void discriminate_sample(input logic [SAMPLE_W-1:0] s,
                                                input logic [BASE_W-1:0] b, input logic l);
        int      need;
        int      t_start;
        int      t_end;
        bit      below;
        result_t r;
        need = (cfg_min_run == 0) ? 1 : int'(cfg_min_run);
        if (wf_idx == 0)
        begin
            base_lat   = b;
            thr_level  = int'(b) - int'(cfg_offset) * 16;
            min_val    = cfg_min_start;
            run_len    = '0;
            start_seen = 1'b0;
            end_seen   = 1'b0;
        end
        if (s < min_val)
            min_val = s;

        below = (int'(s) * 16) < thr_level;
        if (below)
        begin
            if (run_len == 0 && !start_seen)
            begin
                start_idx = wf_idx;
                start_y0  = prev_s;
                start_y1  = s;
            end
            if (run_len != RUN_MAX)
                run_len = run_len + 1'b1;
            if (!start_seen && int'(run_len) >= need)
                start_seen = 1'b1;
        end
        else
        begin
            if (int'(run_len) >= need)
            begin
                end_idx  = wf_idx - 1'b1;
                end_y0   = prev_s;
                end_y1   = s;
                end_seen = 1'b1;
            end
            run_len = '0;
        end
        prev_s = s;

        if (!l)
        begin
            if (wf_idx != IDX_MAX)
                wf_idx = wf_idx + 1'b1;
            return;
        end

        // Waveform end: peak, crossing times, width and status
        r.peak_amplitude = PEAK_W'(int'(base_lat) - int'(min_val) * 16);
        t_start = 0;
        t_end   = 0;
        r.pulse_width = '0;
        if (!start_seen)
        begin
            r.status = STATUS_NO_CROSS;
        end
        else
        begin
            if (start_idx == 0 || start_idx >= wf_idx)
                t_start = int'(start_idx) * 256;
            else
                t_start = (int'(start_idx) - 1) * 256
                        + interp_fraction(int'(start_y0) * 16 - thr_level,
                                          int'(start_y0) - int'(start_y1));
            if (int'(run_len) >= need)
                t_end = int'(wf_idx) * 256;
            else if (end_seen && end_idx != 0)
                t_end = int'(end_idx) * 256
                      + interp_fraction(thr_level - int'(end_y0) * 16,
                                        int'(end_y1) - int'(end_y0));
            if (t_start < t_end)
            begin
                r.status      = STATUS_OK;
                r.pulse_width = TIME_W'(t_end - t_start);
            end
            else
            begin
                r.status = STATUS_ORDER;
            end
        end
        r.start_time = TIME_W'(t_start);
        r.end_time   = TIME_W'(t_end);
        expected_pulses.insert(expected_pulses.size(), r);

        wf_idx     = '0;
        run_len    = '0;
        start_seen = 1'b0;
        end_seen   = 1'b0;
    endfunction

    function automatic void check_field(input string name, input int exp_val, input int got_val);
        if (exp_val != got_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, got_val);
            mismatch_count++;
        end
    endfunction

    function automatic int clamp_adc(input int v);
        if (v < 0)
            return 0;
        if (v > 16383)
            return 16383;
        return v;
    endfunction

    // APB write followed by a readback of the same register
    task automatic program_register(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
        logic [PDATA_W-1:0] stored;
        logic [PDATA_W-1:0] readback;
        case (idx)
            REG_THR_OFFSET:
            begin
                cfg_offset = OFFSET_W'(value);
                stored     = PDATA_W'(cfg_offset);
            end
            REG_MIN_RUN:
            begin
                cfg_min_run = RUN_W'(value);
                stored      = PDATA_W'(cfg_min_run);
            end
            default:
            begin
                cfg_min_start = SAMPLE_W'(value);
                stored        = PDATA_W'(cfg_min_start);
            end
        endcase

        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);

        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field("register readback", int'(stored), int'(readback));
        @(posedge clk);
    endtask

    // Offer one sample word after a random gap and wait for it to be taken
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic [BASE_W-1:0] b,
                               input logic l);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            din_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din_if.valid    <= 1'b1;
        din_if.sample   <= s;
        din_if.baseline <= b;
        din_if.last     <= l;
        @(posedge clk);
        while (!din_if.ready) @(posedge clk);
        discriminate_sample(s, b, l);
        samples_sent++;
    endtask

    // Baseline only matters on the first sample; the rest carry junk
    task automatic send_waveform(input int wave[$], input logic [BASE_W-1:0] base);
        for (int i = 0; i < wave.size(); i++)
            send_sample(SAMPLE_W'(wave[i]), (i == 0) ? base : BASE_W'($urandom),
                        i == wave.size() - 1);
    endtask

    // Quiet stretches near threshold alternating with dips below it, or plain noise
    task automatic send_random_waveform();
        int                wave[$];
        int                len;
        int                lvl;
        int                thr_adc;
        int                span;
        bit                in_dip;
        logic [BASE_W-1:0] base;
        len     = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 48);
        lvl     = $urandom_range(0, 16383);
        base    = BASE_W'(lvl * 16 + $urandom_range(0, 15));
        thr_adc = lvl - int'(cfg_offset);
        if ($urandom_range(0, 9) == 0)
        begin
            // plain noise
            base = BASE_W'($urandom);
            repeat (len) wave.insert(wave.size(), $urandom_range(0, 16383));
        end
        else
        begin
            in_dip = ($urandom_range(0, 3) == 0);
            while (wave.size() < len)
            begin
                if (in_dip)
                begin
                    span = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 20)
                                                       : $urandom_range(1, 6);
                    repeat (span)
                        wave.insert(wave.size(), clamp_adc(thr_adc - $urandom_range(0, 60)));
                end
                else
                begin
                    span = $urandom_range(1, 8);
                    repeat (span)
                        wave.insert(wave.size(), clamp_adc(thr_adc + $urandom_range(0, 40)));
                end
                in_dip = !in_dip;
            end
            while (wave.size() > len) void'(wave.pop_back());
        end
        send_waveform(wave, base);
    endtask

    // Let every pending pulse word come out and the divider go quiet
    task automatic drain_pulses();
        din_if.valid <= 1'b0;
        while (expected_pulses.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Reset register values: no crossing, clean pulse, pulse still low at the end
    task automatic test_basic_pulses();
        send_waveform('{100, 99, 98, 100}, 18'd1600);
        send_waveform('{100, 90, 80, 85, 97, 100}, 18'd1600);
        send_waveform('{100, 90, 80, 70}, 18'd1600);
    endtask

    // Register extremes, zero run length, field extremes, threshold below zero
    task automatic test_edge_settings();
        drain_pulses();
        program_register(REG_THR_OFFSET, 0);
        program_register(REG_MIN_RUN, 0);
        program_register(REG_MIN_START, 16383);
        send_waveform('{16383}, 18'd0);
        send_waveform('{0}, 18'h3FFFF);
        send_waveform('{200, 0, 200}, 18'd1600);

        drain_pulses();
        program_register(REG_THR_OFFSET, 16383);
        program_register(REG_MIN_RUN, 15);
        program_register(REG_MIN_START, 0);
        send_waveform('{0, 0}, 18'd1000);
    endtask

    // Window past MAX_WINDOW with a run that saturates its counter
    task automatic test_long_window();
        int wave[$];
        drain_pulses();
        program_register(REG_THR_OFFSET, 5);
        program_register(REG_MIN_START, 16383);
        repeat (3) wave.insert(wave.size(), 500);
        repeat (1025) wave.insert(wave.size(), 400);
        repeat (2) wave.insert(wave.size(), 500);
        send_waveform(wave, 18'd8000);
    endtask

    // Random waveforms over several register settings and idle patterns
    task automatic test_random_waveforms();
        int phase_end;
        int pick;
        for (int phase = 0; phase < 10; phase++)
        begin
            drain_pulses();
            pick = $urandom_range(0, 7);
            program_register(REG_THR_OFFSET, (pick == 0) ? 0 : (pick == 1) ? 16383 :
                             (pick == 2) ? $urandom_range(0, 16383) : $urandom_range(1, 60));
            pick = $urandom_range(0, 7);
            program_register(REG_MIN_RUN, (pick == 0) ? 0 : (pick == 1) ? 15 :
                             $urandom_range(1, 6));
            pick = $urandom_range(0, 3);
            program_register(REG_MIN_START, (pick == 0) ? 0 : (pick == 1) ? 16383 :
                             $urandom_range(0, 16383));
            gap_max   = $urandom_range(0, 1) * 4;
            stall_max = $urandom_range(0, 1) * 4;
            phase_end = samples_sent + 75;
            while (samples_sent < phase_end) send_random_waveform();
        end
    endtask

    // Result sink: random stall before each word
    initial
    begin
        int hold;
        dout_if.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            hold = $urandom_range(0, stall_max);
            if (hold > 0)
            begin
                dout_if.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            dout_if.ready <= 1'b1;
            @(posedge clk);
            while (!dout_if.valid) @(posedge clk);
        end
    end

    // Compare each accepted pulse word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            if (expected_pulses.size() == 0)
            begin
                $display("%0t: pulse word with none expected, status %0d",
                         $time, dout_if.status);
                mismatch_count++;
            end
            else
            begin
                want = expected_pulses.pop_front();
                check_field("peak_amplitude", int'(want.peak_amplitude),
                            int'(dout_if.peak_amplitude));
                check_field("start_time", int'(want.start_time), int'(dout_if.start_time));
                check_field("end_time", int'(want.end_time), int'(dout_if.end_time));
                check_field("pulse_width", int'(want.pulse_width), int'(dout_if.pulse_width));
                check_field("status", int'(want.status), int'(dout_if.status));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        din_if.valid    <= 1'b0;
        din_if.sample   <= '0;
        din_if.baseline <= '0;
        din_if.last     <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_pulses();
        test_edge_settings();
        test_long_window();
        test_random_waveforms();
        drain_pulses();

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ptct_pkg.sv
rtl/ptct_ifs.sv
rtl/ptct_regs.sv
rtl/ptct_div.sv
rtl/ptct_datapath.sv
rtl/ptct_ctrl.sv
rtl/pulse_threshold_crossing_timer.sv
verif/tb_top.sv
